/* sv/ps2mpt_pkg.sv */
// ----------------------------------------------------------------------------
// ps2mpt_pkg: shared definitions for the PS/2 mouse packet tracker
// Field widths, reset values of the settings and the decoded packet record.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

    // Field widths of the stream beats.
    localparam int BYTE_W    = 8;
    localparam int DX_W      = 10;
    localparam int DY_W      = 11;
    localparam int WHEEL_W   = 8;
    localparam int BUTTONS   = 3;
    localparam int CURSOR_W  = 12;
    localparam int SIZE_W    = 13;
    localparam int OUT_W     = DX_W + DY_W + WHEEL_W + BUTTONS + 2 * CURSOR_W;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;
    localparam int TDATA_W   = OUT_BYTES * 8;

    // Coordinate range of the tracked position.
    localparam int COORD_BITS_DEFAULT = 12;
    localparam int POS_X_RESET        = 512;
    localparam int POS_Y_RESET        = 384;

    // Configuration registers.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WHEEL_ENABLED   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NINE_BIT_FORMAT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT   = 2'd3;

    localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
    localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = 13'd768;

    // Status byte bits.
    localparam int SYNC_BIT    = 3;
    localparam int X_SIGN_BIT  = 4;
    localparam int Y_SIGN_BIT  = 5;
    localparam int X_NINTH_BIT = 6;
    localparam int Y_NINTH_BIT = 7;

    typedef struct packed {
        logic signed [DX_W-1:0]    dx;
        logic signed [DY_W-1:0]    dy;
        logic signed [WHEEL_W-1:0] wheel;
        logic [BUTTONS-1:0]        buttons;
    } decoded_t;

endpackage

/* sv/ps2mpt_assembler.sv */
// ----------------------------------------------------------------------------
// ps2mpt_assembler: packet assembly and delta decoding
// Tracks the byte slot, stores status/X/Y and decodes a finished packet.
// ----------------------------------------------------------------------------
module ps2mpt_assembler (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ps2mpt_pkg::BYTE_W-1:0] in_byte,
    input  logic                          commit,
    input  logic                          wheel_enabled,
    input  logic                          nine_bit_format,
    output logic                          emit,
    output ps2mpt_pkg::decoded_t          pkt
);

    logic [1:0]                    slot_reg;
    logic [1:0]                    slot_next;
    logic [ps2mpt_pkg::BYTE_W-1:0] bytes_reg [3];
    logic                          drop;
    logic                          at_last;
    logic [ps2mpt_pkg::BYTE_W-1:0] status_byte;
    logic [ps2mpt_pkg::BYTE_W-1:0] y_byte;
    logic signed [ps2mpt_pkg::DX_W-1:0] x_ext;
    logic signed [ps2mpt_pkg::DX_W-1:0] y_ext;
    logic signed [ps2mpt_pkg::WHEEL_W-1:0] wheel;

    // In nine-bit mode the status carries bit 8 and the sign; otherwise only the sign.
    function automatic logic signed [ps2mpt_pkg::DX_W-1:0] extend_delta(
        input logic [ps2mpt_pkg::BYTE_W-1:0] raw,
        input logic                          sign,
        input logic                          ninth,
        input logic                          nine_fmt
    );
        logic hi;
        begin
            hi = nine_fmt ? ninth : sign;
            extend_delta = {sign, hi, raw};
        end
    endfunction

    assign drop    = (slot_reg == 2'd0) && !in_byte[ps2mpt_pkg::SYNC_BIT];
    assign at_last = wheel_enabled ? (slot_reg == 2'd3) : (slot_reg >= 2'd2);
    assign emit    = !drop && at_last;

    always_comb begin
        slot_next = slot_reg;
        if (!drop) begin
            slot_next = at_last ? 2'd0 : slot_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= 2'd0;
        end else if (commit) begin
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit && !drop && slot_reg != 2'd3) begin
            bytes_reg[slot_reg] <= in_byte;
        end
    end

    // The Y byte of a three-byte packet is the one arriving now.
    assign status_byte = bytes_reg[0];
    assign y_byte      = (slot_reg == 2'd2) ? in_byte : bytes_reg[2];

    assign x_ext = extend_delta(bytes_reg[1], status_byte[ps2mpt_pkg::X_SIGN_BIT],
                                status_byte[ps2mpt_pkg::X_NINTH_BIT], nine_bit_format);
    assign y_ext = extend_delta(y_byte, status_byte[ps2mpt_pkg::Y_SIGN_BIT],
                                status_byte[ps2mpt_pkg::Y_NINTH_BIT], nine_bit_format);

    assign wheel = (wheel_enabled && slot_reg == 2'd3) ? signed'(in_byte)
                                                       : '0;

    always_comb begin
        pkt.wheel   = wheel;
        pkt.buttons = status_byte[ps2mpt_pkg::BUTTONS-1:0];
        if (wheel != '0) begin
            pkt.dx = '0;
            pkt.dy = '0;
        end else begin
            pkt.dx = x_ext;
            pkt.dy = -(ps2mpt_pkg::DY_W'(y_ext));
        end
    end

endmodule

/* sv/ps2mpt_cursor.sv */
// ----------------------------------------------------------------------------
// ps2mpt_cursor: cursor position accumulator
// Adds the packet deltas to the position and clamps it to the screen.
// ----------------------------------------------------------------------------
module ps2mpt_cursor #(
    parameter int COORD_BITS = ps2mpt_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 commit,
    input  logic signed [ps2mpt_pkg::DX_W-1:0]   dx,
    input  logic signed [ps2mpt_pkg::DY_W-1:0]   dy,
    input  logic [ps2mpt_pkg::SIZE_W-1:0]        screen_width,
    input  logic [ps2mpt_pkg::SIZE_W-1:0]        screen_height,
    output logic [ps2mpt_pkg::CURSOR_W-1:0]      cursor_x,
    output logic [ps2mpt_pkg::CURSOR_W-1:0]      cursor_y
);

    localparam int CMAX    = (1 << COORD_BITS) - 1;
    localparam int RESET_X = (ps2mpt_pkg::POS_X_RESET > CMAX) ? CMAX
                                                              : ps2mpt_pkg::POS_X_RESET;
    localparam int RESET_Y = (ps2mpt_pkg::POS_Y_RESET > CMAX) ? CMAX
                                                              : ps2mpt_pkg::POS_Y_RESET;
    localparam int SUM_W   = ((COORD_BITS > ps2mpt_pkg::SIZE_W) ? COORD_BITS
                                                                : ps2mpt_pkg::SIZE_W) + 2;
    localparam logic signed [SUM_W-1:0] CMAX_S = SUM_W'(CMAX);
    localparam logic signed [SUM_W-1:0] ONE_S  = SUM_W'(1);

    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic [COORD_BITS-1:0] pos_x_next;
    logic [COORD_BITS-1:0] pos_y_next;

    function automatic logic [COORD_BITS-1:0] clamp_axis(
        input logic [COORD_BITS-1:0]              pos,
        input logic signed [ps2mpt_pkg::DY_W-1:0] delta,
        input logic [ps2mpt_pkg::SIZE_W-1:0]      size
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] lim;
        logic signed [SUM_W-1:0] res;
        begin
            sum = SUM_W'(signed'({1'b0, pos})) + SUM_W'(delta);
            lim = (size == '0) ? '0 : SUM_W'(signed'({1'b0, size})) - ONE_S;
            if (lim > CMAX_S) begin
                lim = CMAX_S;
            end
            if (sum < 0) begin
                res = '0;
            end else if (sum > lim) begin
                res = lim;
            end else begin
                res = sum;
            end
            clamp_axis = res[COORD_BITS-1:0];
        end
    endfunction

    assign pos_x_next = clamp_axis(pos_x_reg, ps2mpt_pkg::DY_W'(dx), screen_width);
    assign pos_y_next = clamp_axis(pos_y_reg, dy, screen_height);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= COORD_BITS'(RESET_X);
            pos_y_reg <= COORD_BITS'(RESET_Y);
        end else if (commit) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    assign cursor_x = ps2mpt_pkg::CURSOR_W'(pos_x_next);
    assign cursor_y = ps2mpt_pkg::CURSOR_W'(pos_y_next);

endmodule

/* sv/ps2_mouse_packet_tracker_unit.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit: PS/2 mouse packet tracker, top level
// A packet's last byte stalls in the input register while a result waits on m_axis_tready.
// Throughput: one byte per cycle, set by the input and result registers, unless stalled.
// Reset (aresetn, synchronous, low): slot 0, cursor at 512/384, default settings.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit #(
    parameter int COORD_BITS = ps2mpt_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Byte stream from the PS/2 receiver.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ps2mpt_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] data_byte

    // Decoded packet stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [9:0] delta_x, [20:10] delta_y, [28:21] wheel_delta, [29] left_button,
    // [30] right_button, [31] middle_button, [43:32] cursor_x, [55:44] cursor_y
    output logic [ps2mpt_pkg::TDATA_W-1:0]      m_axis_tdata,

    // Register writes: 0 wheel_enabled, 1 nine_bit_format, 2 screen_width,
    // 3 screen_height.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ps2mpt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ps2mpt_pkg::SIZE_W-1:0]       cfg_data
);

    // Settings. The user must change them only while the block is idle; it does not enforce this.
    logic                           wheel_enabled_reg;
    logic                           nine_bit_format_reg;
    logic [ps2mpt_pkg::SIZE_W-1:0]  screen_width_reg;
    logic [ps2mpt_pkg::SIZE_W-1:0]  screen_height_reg;

    // Input register: one byte waiting to be processed.
    logic                           in_valid_reg;
    logic [ps2mpt_pkg::BYTE_W-1:0]  in_byte_reg;

    // Result register.
    logic                           out_valid_reg;
    logic [ps2mpt_pkg::TDATA_W-1:0] out_data_reg;

    logic                           emit;
    logic                           step;
    logic                           out_free;
    logic                           s_beat;
    ps2mpt_pkg::decoded_t           pkt;
    logic [ps2mpt_pkg::CURSOR_W-1:0] cursor_x;
    logic [ps2mpt_pkg::CURSOR_W-1:0] cursor_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_enabled_reg   <= 1'b0;
            nine_bit_format_reg <= 1'b0;
            screen_width_reg    <= ps2mpt_pkg::SCREEN_WIDTH_RESET;
            screen_height_reg   <= ps2mpt_pkg::SCREEN_HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                ps2mpt_pkg::CFG_WHEEL_ENABLED:   wheel_enabled_reg   <= cfg_data[0];
                ps2mpt_pkg::CFG_NINE_BIT_FORMAT: nine_bit_format_reg <= cfg_data[0];
                ps2mpt_pkg::CFG_SCREEN_WIDTH:    screen_width_reg    <= cfg_data;
                ps2mpt_pkg::CFG_SCREEN_HEIGHT:   screen_height_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The held byte moves on when it produces no result, or when the result
    // register is empty or being emptied in this cycle. A byte that only
    // advances the packet never waits on the output side.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && (!emit || out_free);
    assign s_axis_tready = !in_valid_reg || step;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    ps2mpt_assembler u_assembler (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_byte         (in_byte_reg),
        .commit          (step),
        .wheel_enabled   (wheel_enabled_reg),
        .nine_bit_format (nine_bit_format_reg),
        .emit            (emit),
        .pkt             (pkt)
    );

    // The position advances only with a finished packet.
    ps2mpt_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .commit        (step && emit),
        .dx            (pkt.dx),
        .dy            (pkt.dy),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result beat fields packed from the lowest bit up, zero fill on top.
    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_data_reg <= ps2mpt_pkg::TDATA_W'({cursor_y, cursor_x,
                                                 pkt.buttons[2], pkt.buttons[1],
                                                 pkt.buttons[0], pkt.wheel,
                                                 pkt.dy, pkt.dx});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for ps2_mouse_packet_tracker_unit
// A short table of directed bytes and register writes is followed by random
// packet traffic under several idle patterns. Every result beat is compared
// field by field against a behavioral tracker of packets and cursor position.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 8;      // result pipeline is two deep
    localparam int CYCLE_LIMIT     = 200000;
    localparam int COORD_MAX       = (1 << ps2mpt_pkg::COORD_BITS_DEFAULT) - 1;
    localparam int MODES           = 3;
    localparam int PHASES_PER_MODE = 4;
    localparam int PHASE_ITEMS     = 100;
    localparam int LOW_IDLE_PCT    = 11;
    localparam int HIGH_IDLE_PCT   = 69;
    localparam logic [ps2mpt_pkg::BYTE_W-1:0] SYNC_MASK =
        ps2mpt_pkg::BYTE_W'(1 << ps2mpt_pkg::SYNC_BIT);

    // One decoded result, laid out exactly as m_axis_tdata (last field lowest).
    typedef struct packed {
        logic [ps2mpt_pkg::CURSOR_W-1:0]       cy;
        logic [ps2mpt_pkg::CURSOR_W-1:0]       cx;
        logic                                  middle;
        logic                                  right;
        logic                                  left;
        logic signed [ps2mpt_pkg::WHEEL_W-1:0] wheel;
        logic signed [ps2mpt_pkg::DY_W-1:0]    dy;
        logic signed [ps2mpt_pkg::DX_W-1:0]    dx;
    } mouse_report_t;

    typedef enum {ROW_BYTE, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                          kind;
        logic [ps2mpt_pkg::CFG_INDEX_W-1:0] idx;
        logic [ps2mpt_pkg::SIZE_W-1:0]      value;
        bit                                 typed;
        mouse_report_t                      want;
    } stim_row_t;

    logic                               aclk;
    logic                               aresetn       = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [ps2mpt_pkg::BYTE_W-1:0]      s_axis_tdata  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [ps2mpt_pkg::TDATA_W-1:0]     m_axis_tdata;
    logic                               cfg_valid     = 1'b0;
    logic                               cfg_ready;
    logic [ps2mpt_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [ps2mpt_pkg::SIZE_W-1:0]      cfg_data      = '0;

    // Tracker state and settings, kept in step with the block.
    bit                            wheel_on;
    bit                            nine_bit;
    logic [ps2mpt_pkg::SIZE_W-1:0] width_cfg;
    logic [ps2mpt_pkg::SIZE_W-1:0] height_cfg;
    logic [1:0]                    slot_now;
    logic [7:0]                    pkt_bytes [3];
    int                            pos_x;
    int                            pos_y;

    mouse_report_t moves_due[$];
    int            mismatches  = 0;
    int            items_taken = 0;
    int            cycles      = 0;
    int            snd_idle_pct;
    int            rcv_idle_pct;

    // Directed bytes and register writes. A row with typed set carries the
    // result that its byte completes; the other rows rely on the tracker.
    stim_row_t directed_rows[$] = '{
        // A byte without the sync bit at packet start is dropped.
        '{ROW_BYTE, '0, 13'h000, 1'b0, '0},
        // First packet after reset: all buttons, X of 0x7F, Y of 0x80.
        '{ROW_BYTE, '0, 13'h00F, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h07F, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h080, 1'b1,
          '{dx: 10'sd127, dy: -11'sd128, left: 1'b1, right: 1'b1, middle: 1'b1,
            cx: 12'd639, cy: 12'd256, default: '0}},
        // Both sign bits in 8-bit mode.
        '{ROW_BYTE, '0, 13'h038, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h000, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h000, 1'b1,
          '{dx: -10'sd256, dy: 11'sd256, cx: 12'd383, cy: 12'd512, default: '0}},
        // Wheel on, nine-bit deltas, oversized width, zero height.
        '{ROW_REG, ps2mpt_pkg::CFG_WHEEL_ENABLED,   13'd1,    1'b0, '0},
        '{ROW_REG, ps2mpt_pkg::CFG_NINE_BIT_FORMAT, 13'd1,    1'b0, '0},
        '{ROW_REG, ps2mpt_pkg::CFG_SCREEN_WIDTH,    13'd8191, 1'b0, '0},
        '{ROW_REG, ps2mpt_pkg::CFG_SCREEN_HEIGHT,   13'd0,    1'b0, '0},
        // Largest nine-bit magnitudes: +511 and -511.
        '{ROW_BYTE, '0, 13'h0C8, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h0FF, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h0FF, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h000, 1'b1,
          '{dx: 10'sd511, dy: -11'sd511, cx: 12'd894, cy: 12'd0, default: '0}},
        // Most negative X and most positive Y.
        '{ROW_BYTE, '0, 13'h038, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h000, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h000, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h000, 1'b1,
          '{dx: -10'sd512, dy: 11'sd512, cx: 12'd382, cy: 12'd0, default: '0}},
        // Wheel extremes zero the deltas.
        '{ROW_BYTE, '0, 13'h00F, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h010, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h010, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h080, 1'b1,
          '{wheel: -8'sd128, left: 1'b1, right: 1'b1, middle: 1'b1,
            cx: 12'd382, cy: 12'd0, default: '0}},
        '{ROW_BYTE, '0, 13'h008, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h000, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h000, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h07F, 1'b1,
          '{wheel: 8'sd127, cx: 12'd382, cy: 12'd0, default: '0}},
        // Three bytes in, then the wheel is switched off and the screen shrinks
        // to one column: the fourth byte closes the packet with no wheel, and
        // the cursor that sat beyond the new edge is pulled back to it.
        '{ROW_BYTE, '0, 13'h008, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h001, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h001, 1'b0, '0},
        '{ROW_REG, ps2mpt_pkg::CFG_WHEEL_ENABLED, 13'd0, 1'b0, '0},
        '{ROW_REG, ps2mpt_pkg::CFG_SCREEN_WIDTH,  13'd1, 1'b0, '0},
        '{ROW_BYTE, '0, 13'h055, 1'b1,
          '{dx: 10'sd1, dy: -11'sd1, cx: 12'd0, cy: 12'd0, default: '0}}
    };

    ps2_mouse_packet_tracker_unit #(
        .COORD_BITS(ps2mpt_pkg::COORD_BITS_DEFAULT)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic int widen_delta(input logic [7:0] raw, input logic [7:0] status,
                                       input int sign_bit, input int ninth_bit);
        int v;
        v = int'(raw);
        if (nine_bit) begin
            if (status[ninth_bit]) v += 256;
            if (status[sign_bit]) v -= 512;
        end else if (status[sign_bit]) begin
            v -= 256;
        end
        return v;
    endfunction

    function automatic int axis_limit(input logic [ps2mpt_pkg::SIZE_W-1:0] size);
        int lim;
        lim = (size == 0) ? 0 : int'(size) - 1;
        return (lim > COORD_MAX) ? COORD_MAX : lim;
    endfunction

    function automatic int clamp_coord(input int v, input int hi);
        if (v < 0) return 0;
        return (v > hi) ? hi : v;
    endfunction

    // Feeds one byte to the packet tracker. A dropped byte changes nothing.
    // A finished packet moves the cursor and queues the report it yields.
    function automatic void track_byte(input logic [7:0] b);
        int            last_slot;
        logic [1:0]    slot;
        logic [7:0]    status;
        int            dx;
        int            dy;
        int            w;
        mouse_report_t r;
        last_slot = wheel_on ? 3 : 2;
        slot = slot_now;
        if (slot == 0 && !b[ps2mpt_pkg::SYNC_BIT]) return;
        if (slot < 3) pkt_bytes[slot] = b;
        if (slot < last_slot) begin
            slot_now = slot + 2'd1;
            return;
        end
        slot_now = 2'd0;
        status = pkt_bytes[0];
        w = (wheel_on && slot == 3) ? int'($signed(b)) : 0;
        dx = widen_delta(pkt_bytes[1], status, ps2mpt_pkg::X_SIGN_BIT,
                         ps2mpt_pkg::X_NINTH_BIT);
        dy = -widen_delta(pkt_bytes[2], status, ps2mpt_pkg::Y_SIGN_BIT,
                          ps2mpt_pkg::Y_NINTH_BIT);
        if (w != 0) begin
            dx = 0;
            dy = 0;
        end
        pos_x = clamp_coord(pos_x + dx, axis_limit(width_cfg));
        pos_y = clamp_coord(pos_y + dy, axis_limit(height_cfg));
        r.dx     = dx[ps2mpt_pkg::DX_W-1:0];
        r.dy     = dy[ps2mpt_pkg::DY_W-1:0];
        r.wheel  = w[ps2mpt_pkg::WHEEL_W-1:0];
        r.left   = status[0];
        r.right  = status[1];
        r.middle = status[2];
        r.cx     = pos_x[ps2mpt_pkg::CURSOR_W-1:0];
        r.cy     = pos_y[ps2mpt_pkg::CURSOR_W-1:0];
        moves_due.push_back(r);
    endfunction

    function automatic logic [ps2mpt_pkg::SIZE_W-1:0] screen_size_pick();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ps2mpt_pkg::SIZE_W'(1);
            2:       return ps2mpt_pkg::SIZE_W'(4096);
            3:       return '1;
            4:       return ps2mpt_pkg::SIZE_W'($urandom_range(8191, 4097));
            default: return ps2mpt_pkg::SIZE_W'($urandom_range(4096, 1));
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_beat(input mouse_report_t got, input mouse_report_t want);
        if (got.dx !== want.dx)         flag_mismatch("delta_x", got.dx, want.dx);
        if (got.dy !== want.dy)         flag_mismatch("delta_y", got.dy, want.dy);
        if (got.wheel !== want.wheel)   flag_mismatch("wheel_delta", got.wheel, want.wheel);
        if (got.left !== want.left)     flag_mismatch("left_button", got.left, want.left);
        if (got.right !== want.right)   flag_mismatch("right_button", got.right, want.right);
        if (got.middle !== want.middle) flag_mismatch("middle_button", got.middle, want.middle);
        if (got.cx !== want.cx)         flag_mismatch("cursor_x", got.cx, want.cx);
        if (got.cy !== want.cy)         flag_mismatch("cursor_y", got.cy, want.cy);
    endtask

    // Offers one byte, with random idle cycles ahead of it, and waits for the
    // beat to be taken. Called and returning on a rising edge.
    task automatic take_byte(input logic [7:0] b);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        track_byte(b);
        items_taken++;
    endtask

    task automatic write_reg(input logic [ps2mpt_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ps2mpt_pkg::SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            ps2mpt_pkg::CFG_WHEEL_ENABLED:   wheel_on   = value[0];
            ps2mpt_pkg::CFG_NINE_BIT_FORMAT: nine_bit   = value[0];
            ps2mpt_pkg::CFG_SCREEN_WIDTH:    width_cfg  = value;
            ps2mpt_pkg::CFG_SCREEN_HEIGHT:   height_cfg = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Stops the byte stream and waits for every expected report, then lets the
    // pipeline drain with the stream held idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (moves_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly whole packets with random content, plus dropped noise bytes and
    // cut-short packets that shift the framing.
    task automatic run_traffic(input int target);
        int goal;
        int pick;
        goal = items_taken + target;
        while (items_taken < goal) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                take_byte(8'($urandom()) | SYNC_MASK);
                take_byte(8'($urandom()));
                take_byte(8'($urandom()));
                if (wheel_on) take_byte($urandom_range(1) ? 8'h00 : 8'($urandom()));
            end else if (pick < 95) begin
                take_byte(8'($urandom()) & ~SYNC_MASK);
            end else begin
                take_byte(8'($urandom()) | SYNC_MASK);
                take_byte(8'($urandom()));
            end
        end
    endtask

    // Result side: random back-pressure, and a check of each taken beat.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (moves_due.size() == 0)
                flag_mismatch("result beat with nothing expected", m_axis_tdata, 0);
            else
                check_beat(m_axis_tdata, moves_due.pop_front());
        end
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d reports still expected", $time, moves_due.size());
            $display("** ps2_mouse_packet_tracker_unit: FAILED **");
            $finish;
        end
    end

    initial begin : main_seq
        int mode;
        int phase;
        wheel_on   = 1'b0;
        nine_bit   = 1'b0;
        width_cfg  = ps2mpt_pkg::SCREEN_WIDTH_RESET;
        height_cfg = ps2mpt_pkg::SCREEN_HEIGHT_RESET;
        slot_now   = 2'd0;
        pos_x      = ps2mpt_pkg::POS_X_RESET;
        pos_y      = ps2mpt_pkg::POS_Y_RESET;
        snd_idle_pct = LOW_IDLE_PCT;
        rcv_idle_pct = HIGH_IDLE_PCT;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                settle();
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                take_byte(directed_rows[i].value[ps2mpt_pkg::BYTE_W-1:0]);
                if (directed_rows[i].typed)
                    moves_due[moves_due.size() - 1] = directed_rows[i].want;
            end
        end

        // Sender mostly busy and receiver stalling, then the reverse, then
        // both running flat out. Each phase starts from fresh settings.
        for (mode = 0; mode < MODES; mode++) begin
            case (mode)
                0: begin
                    snd_idle_pct = LOW_IDLE_PCT;
                    rcv_idle_pct = HIGH_IDLE_PCT;
                end
                1: begin
                    snd_idle_pct = HIGH_IDLE_PCT;
                    rcv_idle_pct = LOW_IDLE_PCT;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (phase = 0; phase < PHASES_PER_MODE; phase++) begin
                settle();
                write_reg(ps2mpt_pkg::CFG_WHEEL_ENABLED,
                          ps2mpt_pkg::SIZE_W'($urandom_range(8191)));
                write_reg(ps2mpt_pkg::CFG_NINE_BIT_FORMAT,
                          ps2mpt_pkg::SIZE_W'($urandom_range(8191)));
                write_reg(ps2mpt_pkg::CFG_SCREEN_WIDTH, screen_size_pick());
                write_reg(ps2mpt_pkg::CFG_SCREEN_HEIGHT, screen_size_pick());
                run_traffic(PHASE_ITEMS);
            end
        end

        settle();
        if (mismatches == 0)
            $display("** ps2_mouse_packet_tracker_unit: PASSED **");
        else
            $display("** ps2_mouse_packet_tracker_unit: FAILED **");
        $finish;
    end

endmodule

/* ps2_mouse_packet_tracker_unit.f */
sv/ps2mpt_pkg.sv
sv/ps2mpt_assembler.sv
sv/ps2mpt_cursor.sv
sv/ps2_mouse_packet_tracker_unit.sv
bench/tb_top.sv
